### rtl/saei_pkg.sv
`timescale 1ns / 1ps

package saei_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int MAX_DEGREE   = 16;
  localparam int WEIGHT_BITS  = 16;

  localparam int VTX_W    = 7;
  localparam int FIELD_DEG_W = 5;
  localparam int EDGE_W   = 10;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = $clog2(MAX_VERTICES);
  localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
  localparam int SLOT_W   = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int ENTRY_W  = IDX_W + WEIGHT_BITS;
  localparam int NBR_DEPTH = MAX_VERTICES * MAX_DEGREE;

  localparam logic [VTX_W-1:0] VC_RESET = VTX_W'(64);

  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SMALL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BEYOND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_LOOP   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_DUP    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL   = 3'd5;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDA,
    S_RDB,
    S_LOAD,
    S_SCAN,
    S_SHIFT,
    S_INSERT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [DEG_W-1:0] wr_data;
  } deg_req_t;

endpackage

### rtl/saei_deg_store.sv
`timescale 1ns / 1ps

module saei_deg_store (
  input  logic                        clk,
  input  logic                        rst,
  input  saei_pkg::deg_req_t          req,
  output logic [saei_pkg::DEG_W-1:0]  rd_data
);

  logic [saei_pkg::DEG_W-1:0] mem [saei_pkg::MAX_VERTICES];
  logic [saei_pkg::MAX_VERTICES-1:0] valid;
  logic [saei_pkg::DEG_W-1:0] q;
  logic                       q_valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    q <= mem[req.rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      q_valid <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      q_valid <= valid[req.rd_addr];
    end
  end

  // unwritten entries read as an empty list
  assign rd_data = q_valid ? q : '0;

endmodule

### rtl/sorted_adjacency_edge_insert.sv
`timescale 1ns / 1ps

// Channel   Signals                                       Direction  Handshake
// command   start, cmd, vertex_a, vertex_b, weight        in         start & !busy
// result    done, status, degree_a, degree_b, edge_count  out        done strobe, 1 cycle
// config    cfg_write, cfg_data (vertex_count)            in         cfg_write
//
// An error found on the inputs goes straight to the result; a degree query reads the degree store.
// An add scans the list of vertex_a and then that of vertex_b for the slot of the new neighbour,
// then shifts the larger entries up and inserts in each list; busy is high throughout.
// Reset is synchronous; degree valid bits clear at once, so there is no clearing pass.
// The result is shown for one cycle and cannot be stalled.

module sorted_adjacency_edge_insert (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd,
  input  logic [saei_pkg::VTX_W-1:0]     vertex_a,
  input  logic [saei_pkg::VTX_W-1:0]     vertex_b,
  input  logic signed [15:0]             weight,
  output logic                           done,
  output logic [saei_pkg::STATUS_W-1:0]  status,
  output logic [saei_pkg::FIELD_DEG_W-1:0] degree_a,
  output logic [saei_pkg::FIELD_DEG_W-1:0] degree_b,
  output logic [saei_pkg::EDGE_W-1:0]    edge_count,
  input  logic                           cfg_write,
  input  logic [saei_pkg::VTX_W-1:0]     cfg_data
);

  localparam int IDX_W   = saei_pkg::IDX_W;
  localparam int DEG_W   = saei_pkg::DEG_W;
  localparam int SLOT_W  = saei_pkg::SLOT_W;
  localparam int ENTRY_W = saei_pkg::ENTRY_W;
  localparam int VTX_W   = saei_pkg::VTX_W;
  localparam int ADDR_W  = IDX_W + SLOT_W;
  localparam logic [DEG_W-1:0] FULL_DEG = DEG_W'(saei_pkg::MAX_DEGREE);
  localparam logic [VTX_W-1:0] MAX_VTX  = VTX_W'(saei_pkg::MAX_VERTICES);

  saei_pkg::state_t state, state_next;

  logic [VTX_W-1:0]                  vertex_count;
  logic [saei_pkg::EDGE_W-1:0]       edge_total;
  logic                              cmd_r;
  logic [IDX_W-1:0]                  ua, ub;
  logic [saei_pkg::WEIGHT_BITS-1:0]  wt;
  logic [DEG_W-1:0]                  deg_a, deg_b;
  logic [DEG_W-1:0]                  pos_a, pos_b;
  logic                              side;
  logic [DEG_W-1:0]                  ptr;
  logic                              pend;
  logic [SLOT_W-1:0]                 pslot;
  logic [saei_pkg::STATUS_W-1:0]     status_r;
  logic [saei_pkg::FIELD_DEG_W-1:0]  res_da, res_db;

  logic [ENTRY_W-1:0] nbr_mem [saei_pkg::NBR_DEPTH];
  logic [ENTRY_W-1:0] nbr_q;
  logic               nbr_wr_en;
  logic [ADDR_W-1:0]  nbr_wr_addr, nbr_rd_addr;
  logic [ENTRY_W-1:0] nbr_wr_data;

  saei_pkg::deg_req_t     deg_req;
  logic [DEG_W-1:0]       deg_q;

  logic                              accept;
  logic [VTX_W-1:0]                  vc;
  logic [saei_pkg::STATUS_W-1:0]     in_err;
  logic [DEG_W-1:0]                  cur_deg, cur_pos;
  logic [IDX_W-1:0]                  row, key;
  logic [IDX_W-1:0]                  q_idx;
  logic                              hit_eq, hit_gt, found, scan_issue, scan_end;
  logic [DEG_W-1:0]                  scan_pos;
  logic                              shift_issue, shift_end;
  logic                              full;

  saei_deg_store u_deg (
    .clk     (clk),
    .rst     (rst),
    .req     (deg_req),
    .rd_data (deg_q)
  );

  assign accept = start && (state == saei_pkg::S_IDLE);
  assign vc     = (vertex_count > MAX_VTX) ? MAX_VTX : vertex_count;

  always_comb begin
    in_err = saei_pkg::ST_OK;
    if (cmd == saei_pkg::CMD_QUERY) begin
      if (vertex_a == '0) begin
        in_err = saei_pkg::ST_SMALL;
      end else if (vertex_a > vc) begin
        in_err = saei_pkg::ST_BEYOND;
      end
    end else begin
      if (vertex_a == '0 || vertex_b == '0) begin
        in_err = saei_pkg::ST_SMALL;
      end else if (vertex_a > vc || vertex_b > vc) begin
        in_err = saei_pkg::ST_BEYOND;
      end else if (vertex_a == vertex_b) begin
        in_err = saei_pkg::ST_LOOP;
      end
    end
  end

  assign cur_deg = side ? deg_b : deg_a;
  assign cur_pos = side ? pos_b : pos_a;
  assign row     = side ? ub : ua;
  assign key     = side ? ua : ub;
  assign q_idx   = nbr_q[ENTRY_W-1 -: IDX_W];

  assign hit_eq     = pend && (q_idx == key);
  assign hit_gt     = pend && (q_idx > key);
  assign found      = hit_eq || hit_gt;
  assign scan_issue = !found && (ptr < cur_deg);
  assign scan_end   = found || (!pend && !(ptr < cur_deg));
  assign scan_pos   = found ? DEG_W'(pslot) : cur_deg;

  assign shift_issue = ptr > cur_pos;
  assign shift_end   = !shift_issue && !pend;

  assign full = (deg_a >= FULL_DEG) || (deg_b >= FULL_DEG);

  always_comb begin
    state_next = state;
    unique case (state)
      saei_pkg::S_IDLE: begin
        if (accept) begin
          state_next = (in_err == saei_pkg::ST_OK) ? saei_pkg::S_RDA : saei_pkg::S_DONE;
        end
      end
      saei_pkg::S_RDA: state_next = saei_pkg::S_RDB;
      saei_pkg::S_RDB: begin
        state_next = (cmd_r == saei_pkg::CMD_QUERY) ? saei_pkg::S_DONE : saei_pkg::S_LOAD;
      end
      saei_pkg::S_LOAD: state_next = saei_pkg::S_SCAN;
      saei_pkg::S_SCAN: begin
        if (scan_end) begin
          if (hit_eq) begin
            state_next = saei_pkg::S_DONE;
          end else if (side) begin
            state_next = full ? saei_pkg::S_DONE : saei_pkg::S_SHIFT;
          end
        end
      end
      saei_pkg::S_SHIFT: begin
        if (shift_end) begin
          state_next = saei_pkg::S_INSERT;
        end
      end
      saei_pkg::S_INSERT: begin
        state_next = side ? saei_pkg::S_DONE : saei_pkg::S_SHIFT;
      end
      saei_pkg::S_DONE: state_next = saei_pkg::S_IDLE;
      default: state_next = saei_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy            = (state != saei_pkg::S_IDLE);
    done            = (state == saei_pkg::S_DONE);
    deg_req.rd_addr = ua;
    deg_req.wr_en   = 1'b0;
    deg_req.wr_addr = row;
    deg_req.wr_data = cur_deg + DEG_W'(1);
    nbr_rd_addr     = {row, ptr[SLOT_W-1:0]};
    nbr_wr_en       = 1'b0;
    nbr_wr_addr     = {row, pslot};
    nbr_wr_data     = nbr_q;
    unique case (state)
      saei_pkg::S_RDB: deg_req.rd_addr = ub;
      saei_pkg::S_SHIFT: begin
        nbr_rd_addr = {row, SLOT_W'(ptr - DEG_W'(1))};
        nbr_wr_en   = pend;
      end
      saei_pkg::S_INSERT: begin
        nbr_wr_en     = 1'b1;
        nbr_wr_addr   = {row, cur_pos[SLOT_W-1:0]};
        nbr_wr_data   = {key, wt};
        deg_req.wr_en = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (nbr_wr_en) begin
      nbr_mem[nbr_wr_addr] <= nbr_wr_data;
    end
    nbr_q <= nbr_mem[nbr_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= saei_pkg::S_IDLE;
      vertex_count <= saei_pkg::VC_RESET;
      edge_total   <= '0;
      pend         <= 1'b0;
      side         <= 1'b0;
      ptr          <= '0;
    end else begin
      state <= state_next;
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      unique case (state)
        saei_pkg::S_IDLE: begin
          if (accept) begin
            cmd_r    <= cmd;
            ua       <= IDX_W'(vertex_a - VTX_W'(1));
            ub       <= IDX_W'(vertex_b - VTX_W'(1));
            wt       <= weight[saei_pkg::WEIGHT_BITS-1:0];
            status_r <= in_err;
            res_da   <= '0;
            res_db   <= '0;
          end
        end
        saei_pkg::S_RDB: begin
          deg_a <= deg_q;
          if (cmd_r == saei_pkg::CMD_QUERY) begin
            res_da <= saei_pkg::FIELD_DEG_W'(deg_q);
          end
        end
        saei_pkg::S_LOAD: begin
          deg_b <= deg_q;
          side  <= 1'b0;
          ptr   <= '0;
          pend  <= 1'b0;
        end
        saei_pkg::S_SCAN: begin
          if (scan_end) begin
            pend <= 1'b0;
            if (side) begin
              pos_b <= scan_pos;
            end else begin
              pos_a <= scan_pos;
            end
            if (hit_eq) begin
              status_r <= saei_pkg::ST_DUP;
            end else if (side) begin
              side <= 1'b0;
              ptr  <= deg_a;
              if (full) begin
                status_r <= saei_pkg::ST_FULL;
              end
            end else begin
              side <= 1'b1;
              ptr  <= '0;
            end
          end else begin
            pend <= scan_issue;
            if (scan_issue) begin
              pslot <= ptr[SLOT_W-1:0];
              ptr   <= ptr + DEG_W'(1);
            end
          end
        end
        saei_pkg::S_SHIFT: begin
          pend <= shift_issue;
          if (shift_issue) begin
            pslot <= ptr[SLOT_W-1:0];
            ptr   <= ptr - DEG_W'(1);
          end
        end
        saei_pkg::S_INSERT: begin
          if (side) begin
            edge_total <= edge_total + saei_pkg::EDGE_W'(1);
            res_da     <= saei_pkg::FIELD_DEG_W'(deg_a + DEG_W'(1));
            res_db     <= saei_pkg::FIELD_DEG_W'(deg_b + DEG_W'(1));
          end else begin
            side <= 1'b1;
            ptr  <= deg_b;
          end
        end
        default: ;
      endcase
    end
  end

  assign status     = status_r;
  assign degree_a   = res_da;
  assign degree_b   = res_db;
  assign edge_count = edge_total;

endmodule
